### src/cpi_pkg.sv
`timescale 1ns / 1ps
// Package for the first-seen colour palette indexer: sizes, codes and the
// word type that travels along the row of search cells. No dependencies.
package cpi_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int COLOR_W       = 24;
    localparam int LABEL_W       = 16;
    localparam int CFG_ADDR_W    = 1;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_BACKGROUND = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_NOT_FOUND  = 1'b1;

    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_BLACK = 2'd1;
    localparam logic [1:0] RES_HIT   = 2'd2;
    localparam logic [1:0] RES_NEW   = 2'd3;

    typedef struct packed {
        logic               kind;
        logic [COLOR_W-1:0] color;
        logic [1:0]         res;
        logic [IDX_W-1:0]   idx;
    } cpi_token_t;

endpackage

### src/color_to_label_palette_indexer_core.sv
`timescale 1ns / 1ps
// Top level of the first-seen colour palette indexer: a row of search cells
// and the label output register. Depends on cpi_pkg and cpi_cell.
//
//  Channel  Direction  Contents
//  s_       in         tdata: red, green, blue; tuser: kind (1 = restart)
//  m_       out        tdata: label; tuser: is_new, store_full
//  cfg_     in         index 0 background label, index 1 not-found label
//
// A word moves one cell per cycle along the row of TABLE_ENTRIES cells and
// then into the output register, each step held while m_ stalls; one word
// is taken every cycle that m_ does not stall.
// Reset empties every cell at once. A restart word empties each cell as it
// passes and gives no output. A stall on m_ freezes the whole row.
module color_to_label_palette_indexer_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cpi_pkg::COLOR_W-1:0]      s_tdata,   // red, green, blue
    input  logic                             s_tuser,   // kind
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cpi_pkg::LABEL_W-1:0]      m_tdata,   // label
    output logic [1:0]                       m_tuser,   // is_new, store_full
    input  logic                             cfg_wen,
    input  logic [cpi_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [cpi_pkg::LABEL_W-1:0]      cfg_wdata
);
    import cpi_pkg::*;

    logic [LABEL_W-1:0] background_reg;
    logic [LABEL_W-1:0] not_found_reg;
    logic               advance;
    logic               chain_valid [0:TABLE_ENTRIES];
    cpi_token_t         chain_tok   [0:TABLE_ENTRIES];
    cpi_token_t         last_tok;
    logic               m_valid_reg, m_valid_next;
    logic [LABEL_W-1:0] m_label_reg, m_label_next;
    logic [1:0]         m_flags_reg, m_flags_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            background_reg <= '0;
            not_found_reg  <= LABEL_W'(404);
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_BACKGROUND: background_reg <= cfg_wdata;
                REG_NOT_FOUND:  not_found_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = advance;

    always_comb begin
        chain_valid[0]     = s_tvalid;
        chain_tok[0].kind  = s_tuser;
        chain_tok[0].color = s_tdata;
        chain_tok[0].idx   = '0;
        chain_tok[0].res   = ((s_tuser == KIND_PIXEL) && (s_tdata == '0)) ? RES_BLACK
                                                                          : RES_NONE;
    end

    genvar i;
    generate
        for (i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
            cpi_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .advance    (advance),
                .cell_index (IDX_W'(i)),
                .in_valid   (chain_valid[i]),
                .in_tok     (chain_tok[i]),
                .out_valid  (chain_valid[i+1]),
                .out_tok    (chain_tok[i+1])
            );
        end
    endgenerate

    assign last_tok = chain_tok[TABLE_ENTRIES];

    always_comb begin
        m_valid_next = chain_valid[TABLE_ENTRIES] && (last_tok.kind == KIND_PIXEL);
        unique case (last_tok.res)
            RES_BLACK: begin
                m_label_next = background_reg;
                m_flags_next = 2'b00;
            end
            RES_HIT: begin
                m_label_next = background_reg + LABEL_W'(1) + LABEL_W'(last_tok.idx);
                m_flags_next = 2'b00;
            end
            RES_NEW: begin
                m_label_next = background_reg + LABEL_W'(1) + LABEL_W'(last_tok.idx);
                m_flags_next = 2'b01;
            end
            default: begin
                m_label_next = not_found_reg;
                m_flags_next = 2'b10;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_label_reg <= m_label_next;
            m_flags_reg <= m_flags_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_label_reg;
    assign m_tuser  = m_flags_reg;

endmodule

### src/cpi_cell.sv
`timescale 1ns / 1ps
// One search cell: holds one stored colour and passes a word to its neighbour.
// Depends on cpi_pkg.
module cpi_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic [cpi_pkg::IDX_W-1:0] cell_index,
    input  logic                   in_valid,
    input  cpi_pkg::cpi_token_t    in_tok,
    output logic                   out_valid,
    output cpi_pkg::cpi_token_t    out_tok
);
    import cpi_pkg::*;

    logic               used_reg, used_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic               tok_valid_reg;
    cpi_token_t         tok_reg, tok_next;
    logic               match;

    assign match = used_reg && (color_reg == in_tok.color);

    always_comb begin
        tok_next   = in_tok;
        used_next  = used_reg;
        color_next = color_reg;
        if (in_valid) begin
            if (in_tok.kind == KIND_RESTART) begin
                used_next = 1'b0;
            end else if (in_tok.res == RES_NONE) begin
                if (match) begin
                    tok_next.res = RES_HIT;
                    tok_next.idx = cell_index;
                end else if (!used_reg) begin
                    tok_next.res = RES_NEW;
                    tok_next.idx = cell_index;
                    used_next    = 1'b1;
                    color_next   = in_tok.color;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else if (advance) begin
            used_reg      <= used_next;
            tok_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            color_reg <= color_next;
            tok_reg   <= tok_next;
        end
    end

    assign out_valid = tok_valid_reg;
    assign out_tok   = tok_reg;

endmodule

### sim/color_to_label_palette_indexer_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the colour palette indexer core: random stream traffic on both
// sides, register settings between images, and a predictor of the labels the core should give.
// Depends on cpi_pkg and color_to_label_palette_indexer_core.
module color_to_label_palette_indexer_core_test;

    localparam int DRAIN_CYCLES = 2 * cpi_pkg::TABLE_ENTRIES + 16;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_word_t;

    typedef struct packed {
        logic [cpi_pkg::LABEL_W-1:0] label;
        logic                        is_new;
        logic                        store_full;
    } label_word_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [cpi_pkg::COLOR_W-1:0]       s_tdata = '0;
    logic                              s_tuser = cpi_pkg::KIND_PIXEL;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [cpi_pkg::LABEL_W-1:0]       m_tdata;
    logic [1:0]                        m_tuser;
    logic                              cfg_wen = 1'b0;
    logic [cpi_pkg::CFG_ADDR_W-1:0]    cfg_addr = cpi_pkg::REG_BACKGROUND;
    logic [cpi_pkg::LABEL_W-1:0]       cfg_wdata = '0;

    pixel_word_t                       pixel_queue[$];
    label_word_t                       label_fifo[$];

    logic [cpi_pkg::COLOR_W-1:0]       seen_color [0:cpi_pkg::TABLE_ENTRIES-1];
    int                                seen_count = 0;
    logic [cpi_pkg::LABEL_W-1:0]       bg_label = 16'd0;
    logic [cpi_pkg::LABEL_W-1:0]       nf_label = 16'd404;

    logic [cpi_pkg::COLOR_W-1:0]       palette [0:511];
    int                                queued_items = 0;
    int                                fail_count = 0;
    int                                gap_left = 0;
    int                                stall_left = 0;
    logic                              taken_r = 1'b0;
    bit                                tx_calm = 1'b0;
    bit                                rx_calm = 1'b0;

    color_to_label_palette_indexer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // red, green, blue
        .s_tuser   (s_tuser),    // kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // label
        .m_tuser   (m_tuser),    // is_new, store_full
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    task automatic label_pixel(input pixel_word_t w);
        logic [cpi_pkg::COLOR_W-1:0] c;
        label_word_t                 r;
        int                          hit;
        int                          k;
        c = {w.red, w.green, w.blue};
        hit = -1;
        r.label = '0;
        r.is_new = 1'b0;
        r.store_full = 1'b0;
        if (w.kind == cpi_pkg::KIND_RESTART) begin
            seen_count = 0;
        end else begin
            if (c == '0) begin
                r.label = bg_label;
            end else begin
                for (k = 0; k < seen_count; k++) begin
                    if (hit < 0 && seen_color[k] == c) begin
                        hit = k;
                    end
                end
                if (hit >= 0) begin
                    r.label = bg_label + 16'd1 + hit[15:0];
                end else if (seen_count < cpi_pkg::TABLE_ENTRIES) begin
                    seen_color[seen_count] = c;
                    r.label = bg_label + 16'd1 + seen_count[15:0];
                    r.is_new = 1'b1;
                    seen_count++;
                end else begin
                    r.label = nf_label;
                    r.store_full = 1'b1;
                end
            end
            label_fifo = {label_fifo, r};
        end
    endtask

    always @(posedge aclk) begin
        taken_r <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            label_pixel(pixel_word_t'({s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]}));
        end
    end

    always @(negedge aclk) begin
        pixel_word_t w;
        if (aresetn && (!s_tvalid || taken_r)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                w = pixel_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {w.blue, w.green, w.red};
                s_tuser <= w.kind;
                gap_left <= pick_gap(tx_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left <= pick_gap(rx_calm);
        end
    end

    always @(posedge aclk) begin
        label_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (label_fifo.size() == 0) begin
                $error("unexpected label word: label %0d, tuser %b", m_tdata, m_tuser);
                fail_count <= fail_count + 1;
            end else begin
                e = label_fifo.pop_front();
                if (m_tdata !== e.label || m_tuser[0] !== e.is_new
                        || m_tuser[1] !== e.store_full) begin
                    fail_count <= fail_count + 1;
                end
                if (m_tdata !== e.label) begin
                    $error("label: expected %0d, got %0d", e.label, m_tdata);
                end
                if (m_tuser[0] !== e.is_new) begin
                    $error("is_new: expected %0d, got %0d", e.is_new, m_tuser[0]);
                end
                if (m_tuser[1] !== e.store_full) begin
                    $error("store_full: expected %0d, got %0d", e.store_full, m_tuser[1]);
                end
            end
        end
    end

    task automatic push_word(input logic kind, input logic [cpi_pkg::COLOR_W-1:0] c);
        pixel_word_t w;
        w.kind = kind;
        w.red = c[23:16];
        w.green = c[15:8];
        w.blue = c[7:0];
        pixel_queue = {pixel_queue, w};
        queued_items++;
    endtask

    task automatic settle_block();
        int ready_cycles;
        ready_cycles = 0;
        while (pixel_queue.size() != 0 || s_tvalid || label_fifo.size() != 0) begin
            @(posedge aclk);
        end
        while (ready_cycles < DRAIN_CYCLES) begin
            @(posedge aclk);
            if (m_tready) begin
                ready_cycles++;
            end
        end
    endtask

    task automatic write_reg(input logic [cpi_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [cpi_pkg::LABEL_W-1:0] data);
        @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        if (addr == cpi_pkg::REG_BACKGROUND) begin
            bg_label = data;
        end else begin
            nf_label = data;
        end
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    task automatic build_palette(input int n);
        logic [cpi_pkg::COLOR_W-1:0] c;
        bit                          clash;
        int                          i;
        int                          j;
        for (i = 0; i < n; i++) begin
            do begin
                c = 24'($urandom);
                clash = (c == '0);
                for (j = 0; j < i; j++) begin
                    if (palette[j] == c) begin
                        clash = 1'b1;
                    end
                end
            end while (clash);
            palette[i] = c;
        end
    endtask

    // Colours of the palette are introduced in order, so a large palette fills the store.
    task automatic run_image(input int n, input bit lead_restart);
        int n_pix;
        int next_new;
        int i;
        int r;
        if (lead_restart) begin
            push_word(cpi_pkg::KIND_RESTART, 24'($urandom));
        end
        build_palette(n);
        n_pix = n + n / 5 + $urandom_range(5, 60);
        next_new = 0;
        for (i = 0; i < n_pix; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                push_word(cpi_pkg::KIND_PIXEL, '0);
            end else if (r < 13) begin
                push_word(cpi_pkg::KIND_PIXEL, 24'($urandom));
            end else if (r < 15 && n < 100) begin
                push_word(cpi_pkg::KIND_RESTART, 24'($urandom));
            end else if (next_new < n) begin
                push_word(cpi_pkg::KIND_PIXEL, palette[next_new]);
                next_new++;
            end else begin
                push_word(cpi_pkg::KIND_PIXEL, palette[$urandom_range(0, n - 1)]);
            end
        end
    endtask

    initial begin
        int n_images;
        int k;
        int sel;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register values straight out of reset.
        push_word(cpi_pkg::KIND_PIXEL, 24'h000000);
        push_word(cpi_pkg::KIND_PIXEL, 24'hFFFFFF);
        push_word(cpi_pkg::KIND_PIXEL, 24'hFF0000);
        push_word(cpi_pkg::KIND_PIXEL, 24'h00FF00);
        push_word(cpi_pkg::KIND_PIXEL, 24'h0000FF);
        push_word(cpi_pkg::KIND_PIXEL, 24'hFFFFFF);
        push_word(cpi_pkg::KIND_PIXEL, 24'h010000);
        push_word(cpi_pkg::KIND_PIXEL, 24'h000000);
        push_word(cpi_pkg::KIND_RESTART, 24'hFFFFFF);
        push_word(cpi_pkg::KIND_PIXEL, 24'h0000FF);
        push_word(cpi_pkg::KIND_RESTART, 24'h000000);
        push_word(cpi_pkg::KIND_RESTART, 24'h5A5A5A);
        push_word(cpi_pkg::KIND_PIXEL, 24'hFF0000);
        settle_block();

        // The label sequence wraps straight after the top value.
        write_reg(cpi_pkg::REG_BACKGROUND, 16'hFFFF);
        write_reg(cpi_pkg::REG_NOT_FOUND, 16'h0000);
        push_word(cpi_pkg::KIND_RESTART, 24'hA5C3E1);
        push_word(cpi_pkg::KIND_PIXEL, 24'h000000);
        push_word(cpi_pkg::KIND_PIXEL, 24'h123456);
        push_word(cpi_pkg::KIND_PIXEL, 24'h654321);
        push_word(cpi_pkg::KIND_PIXEL, 24'h123456);
        settle_block();

        queued_items = 0;
        write_reg(cpi_pkg::REG_BACKGROUND, 16'd65300);
        write_reg(cpi_pkg::REG_NOT_FOUND, 16'hFFFF);
        run_image(300, 1'b1);
        settle_block();

        while (queued_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 4);
            case (sel)
                0: begin
                    write_reg(cpi_pkg::REG_BACKGROUND, 16'h0000);
                    write_reg(cpi_pkg::REG_NOT_FOUND, 16'hFFFF);
                end
                1: begin
                    write_reg(cpi_pkg::REG_BACKGROUND, 16'hFFFF);
                    write_reg(cpi_pkg::REG_NOT_FOUND, 16'h0000);
                end
                2: begin
                    write_reg(cpi_pkg::REG_BACKGROUND, 16'(16'hFFFF - $urandom_range(0, 300)));
                    write_reg(cpi_pkg::REG_NOT_FOUND, 16'($urandom));
                end
                3: begin
                    write_reg(cpi_pkg::REG_BACKGROUND, 16'd0);
                    write_reg(cpi_pkg::REG_NOT_FOUND, 16'd404);
                end
                default: begin
                    write_reg(cpi_pkg::REG_BACKGROUND, 16'($urandom));
                    write_reg(cpi_pkg::REG_NOT_FOUND, 16'($urandom));
                end
            endcase
            tx_calm = ($urandom_range(0, 99) < 20);
            rx_calm = ($urandom_range(0, 99) < 20);
            n_images = $urandom_range(1, 3);
            for (k = 0; k < n_images && queued_items < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) < 12) begin
                    run_image($urandom_range(250, 300), 1'b1);
                end else begin
                    run_image($urandom_range(1, 40), (k > 0) || ($urandom_range(0, 99) < 75));
                end
            end
            settle_block();
        end

        if (fail_count == 0 && label_fifo.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### color_to_label_palette_indexer_core.f
src/cpi_pkg.sv
src/cpi_cell.sv
src/color_to_label_palette_indexer_core.sv
sim/color_to_label_palette_indexer_core_test.sv
